[design/biq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the biquad filter (direct form II).
// Depends on nothing; every other file but biq_checker refers to it by scoped names.
`default_nettype none

package biq_pkg;

    localparam int COEF_BITS  = 18;
    localparam int DELAY_BITS = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CNT_W      = $clog2(COEF_BITS);

    typedef logic signed [COEF_BITS-1:0]  t_coef;
    typedef logic signed [DELAY_BITS-1:0] t_delay;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } t_cfg_reg;

    localparam t_coef COEF_B0_RST = 18'sd16384;
    localparam t_coef COEF_B1_RST = -18'sd32768;
    localparam t_coef COEF_B2_RST = 18'sd16384;
    localparam t_coef COEF_A1_RST = -18'sd3277;
    localparam t_coef COEF_A2_RST = 18'sd2785;

    typedef struct packed {
        t_coef b0;
        t_coef b1;
        t_coef b2;
        t_coef a1;
        t_coef a2;
    } t_coefs;

    // Commands from the sequencer to the serial multiply-accumulate unit.
    typedef struct packed {
        logic init;   // load the accumulator
        logic start;  // begin one coefficient times delay product
        logic sub;    // subtract the product instead of adding it
    } t_mac_cmd;

endpackage

`default_nettype wire

[design/biq_ifs.sv]
`timescale 1ns / 1ps
// Channel interfaces of the biquad filter: input samples, output samples,
// coefficient writes. Depends on biq_pkg for the register index and coefficient widths.
`default_nettype none

interface biq_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface biq_out_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface biq_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [biq_pkg::CFG_IDX_W-1:0]    reg_index;
    logic [biq_pkg::COEF_BITS-1:0]    wdata;
    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

[design/biq_coef_regs.sv]
`timescale 1ns / 1ps
// Coefficient register file of the biquad filter, written over the config channel.
// Depends on biq_pkg and biq_cfg_if.
`default_nettype none

module biq_coef_regs (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    biq_cfg_if.sink             i_cfg,
    output biq_pkg::t_coefs     o_coefs
);

    biq_pkg::t_coefs r_coefs;

    assign i_cfg.ready = 1'b1;
    assign o_coefs     = r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= biq_pkg::COEF_B0_RST;
            r_coefs.b1 <= biq_pkg::COEF_B1_RST;
            r_coefs.b2 <= biq_pkg::COEF_B2_RST;
            r_coefs.a1 <= biq_pkg::COEF_A1_RST;
            r_coefs.a2 <= biq_pkg::COEF_A2_RST;
        end else if (i_cfg.valid) begin
            // drop writes to indexes beyond the register list
            unique case (biq_pkg::t_cfg_reg'(i_cfg.reg_index))
                biq_pkg::REG_B0: r_coefs.b0 <= i_cfg.wdata;
                biq_pkg::REG_B1: r_coefs.b1 <= i_cfg.wdata;
                biq_pkg::REG_B2: r_coefs.b2 <= i_cfg.wdata;
                biq_pkg::REG_A1: r_coefs.a1 <= i_cfg.wdata;
                biq_pkg::REG_A2: r_coefs.a2 <= i_cfg.wdata;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/biq_serial_mac.sv]
`timescale 1ns / 1ps
// Bit-serial multiply-accumulate: one coefficient bit per cycle, shift and add.
// Depends on biq_pkg.
`default_nettype none

module biq_serial_mac #(
    parameter int ACC_W = 45
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire biq_pkg::t_mac_cmd       i_cmd,
    input  wire biq_pkg::t_coef          i_coef,
    input  wire biq_pkg::t_delay         i_mcand,
    input  wire logic signed [ACC_W-1:0] i_init_val,
    output logic signed [ACC_W-1:0]      o_acc,
    output logic                         o_busy
);

    logic signed [ACC_W-1:0]               r_acc;
    logic signed [ACC_W-1:0]               r_mcand;
    logic [biq_pkg::COEF_BITS-1:0]         r_coef;
    logic [biq_pkg::CNT_W-1:0]             r_cnt;
    logic                                  r_busy;
    logic                                  r_sub;

    logic                                  w_last;
    logic                                  w_neg;
    logic signed [ACC_W-1:0]               w_term;
    logic signed [ACC_W-1:0]               n_acc;

    assign o_acc  = r_acc;
    assign o_busy = r_busy;

    always_comb begin
        w_last = (r_cnt == biq_pkg::CNT_W'(biq_pkg::COEF_BITS - 1));
        w_term = r_coef[0] ? r_mcand : '0;
        // the top coefficient bit carries negative weight
        w_neg  = w_last ^ r_sub;
        n_acc  = w_neg ? (r_acc - w_term) : (r_acc + w_term);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_acc <= i_init_val;
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
        if (i_cmd.start) begin
            r_coef  <= i_coef;
            r_mcand <= {{(ACC_W-biq_pkg::DELAY_BITS){i_mcand[biq_pkg::DELAY_BITS-1]}},
                        i_mcand};
            r_sub   <= i_cmd.sub;
        end else if (r_busy) begin
            r_coef  <= r_coef >> 1;
            r_mcand <= r_mcand <<< 1;
        end
    end

endmodule

`default_nettype wire

[design/biquad_direct_form2_filter_top.sv]
`timescale 1ns / 1ps
// Biquad IIR filter, direct form II, with a bit-serial multiply-accumulate unit.
// Depends on biq_pkg, biq_ifs, biq_coef_regs and biq_serial_mac.
//
//   channel    dir  payload                          request moved
//   i_sample   in   sample_in  (SAMPLE_BITS, s)      one input sample
//   o_sample   out  sample_out (SAMPLE_BITS, s)      one filtered sample
//   i_cfg      in   reg_index (3), wdata (18)        one coefficient write
//
// Each sample takes five coefficient products in the shared bit-serial
// multiply-accumulate unit, each with an issue and a completion step, plus
// the feedback and output rounding steps.
// Reset (synchronous, active low) restores the default coefficients and clears
// both delay values. A stalled result waits in the output register; the next
// sample is still taken, and only its final write-back waits for the slot.
`default_nettype none

module biquad_direct_form2_filter_top #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    biq_in_if.sink     i_sample,
    biq_out_if.source  o_sample,
    biq_cfg_if.sink    i_cfg
);

    localparam int PROD_W = biq_pkg::COEF_BITS + biq_pkg::DELAY_BITS;
    localparam int X_W    = SAMPLE_BITS + COEF_FRAC_BITS;
    localparam int ACC_W  = ((X_W > PROD_W) ? X_W : PROD_W) + 3;
    localparam int DB     = biq_pkg::DELAY_BITS;

    localparam logic signed [ACC_W-1:0] HALF =
        {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] W_MAX = {{(ACC_W-DB+1){1'b0}}, {(DB-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] W_MIN = {{(ACC_W-DB+1){1'b1}}, {(DB-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] Y_MAX =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] Y_MIN =
        {{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_W,
        S_Y
    } t_state;

    typedef enum logic [2:0] {
        T_A1,
        T_A2,
        T_B0,
        T_B1,
        T_B2
    } t_term;

    t_state                        r_state;
    t_term                         r_term;
    biq_pkg::t_delay               r_d1;
    biq_pkg::t_delay               r_d2;
    biq_pkg::t_delay               r_w;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_data;

    biq_pkg::t_coefs               w_coefs;
    biq_pkg::t_mac_cmd             w_cmd;
    biq_pkg::t_coef                w_coef;
    biq_pkg::t_delay               w_mcand;
    logic signed [ACC_W-1:0]       w_init_val;
    logic signed [ACC_W-1:0]       w_acc;
    logic                          w_busy;
    logic                          w_accept;
    logic signed [ACC_W-1:0]       w_rnd;
    biq_pkg::t_delay               w_wsat;
    logic signed [SAMPLE_BITS-1:0] w_ysat;
    logic                          w_slot_free;

    biq_coef_regs u_coef_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_coefs (w_coefs)
    );

    biq_serial_mac #(.ACC_W(ACC_W)) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_coef     (w_coef),
        .i_mcand    (w_mcand),
        .i_init_val (w_init_val),
        .o_acc      (w_acc),
        .o_busy     (w_busy)
    );

    assign i_sample.ready      = (r_state == S_IDLE);
    assign w_accept            = i_sample.valid && (r_state == S_IDLE);
    assign o_sample.valid      = r_out_valid;
    assign o_sample.sample_out = r_out_data;
    assign w_slot_free         = !r_out_valid || o_sample.ready;

    always_comb begin
        w_cmd.init  = w_accept || (r_state == S_W);
        w_cmd.start = (r_state == S_ISSUE);
        w_cmd.sub   = (r_term == T_A1) || (r_term == T_A2);
        // feedback pass starts from x scaled to the accumulator's fraction
        w_init_val  = (r_state == S_IDLE)
            ? {{(ACC_W-X_W){i_sample.sample_in[SAMPLE_BITS-1]}},
               i_sample.sample_in, {COEF_FRAC_BITS{1'b0}}}
            : '0;
        unique case (r_term)
            T_A1: begin w_coef = w_coefs.a1; w_mcand = r_d1; end
            T_A2: begin w_coef = w_coefs.a2; w_mcand = r_d2; end
            T_B0: begin w_coef = w_coefs.b0; w_mcand = r_w;  end
            T_B1: begin w_coef = w_coefs.b1; w_mcand = r_d1; end
            T_B2: begin w_coef = w_coefs.b2; w_mcand = r_d2; end
            default: begin w_coef = '0; w_mcand = '0; end
        endcase
    end

    // round to nearest (add half, floor), then clamp
    always_comb begin
        w_rnd = (w_acc + HALF) >>> COEF_FRAC_BITS;
        priority if (w_rnd > W_MAX) begin
            w_wsat = W_MAX[DB-1:0];
        end else if (w_rnd < W_MIN) begin
            w_wsat = W_MIN[DB-1:0];
        end else begin
            w_wsat = w_rnd[DB-1:0];
        end
        priority if (w_rnd > Y_MAX) begin
            w_ysat = Y_MAX[SAMPLE_BITS-1:0];
        end else if (w_rnd < Y_MIN) begin
            w_ysat = Y_MIN[SAMPLE_BITS-1:0];
        end else begin
            w_ysat = w_rnd[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_term      <= T_A1;
            r_out_valid <= 1'b0;
            r_d1        <= '0;
            r_d2        <= '0;
        end else begin
            if ((r_state == S_Y) && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (o_sample.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_term  <= T_A1;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (!w_busy) begin
                        unique case (r_term)
                            T_A1: begin r_term <= T_A2; r_state <= S_ISSUE; end
                            T_A2: r_state <= S_W;
                            T_B0: begin r_term <= T_B1; r_state <= S_ISSUE; end
                            T_B1: begin r_term <= T_B2; r_state <= S_ISSUE; end
                            T_B2: r_state <= S_Y;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_W: begin
                    r_w     <= w_wsat;
                    r_term  <= T_B0;
                    r_state <= S_ISSUE;
                end
                S_Y: begin
                    // hold until the output register is free
                    if (w_slot_free) begin
                        r_out_data  <= w_ysat;
                        r_d2        <= r_d1;
                        r_d1        <= r_w;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/biq_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the biquad filter top, attached by bind.
// Depends on biquad_direct_form2_filter_top and its channel interfaces.
`default_nettype none

module biq_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_valid,
    input wire logic                   i_in_ready,
    input wire logic                   i_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [SAMPLE_BITS-1:0] i_out_data,
    input wire logic                   i_cfg_ready
);

    // one sample in flight: ready drops right after a request is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready stayed high after a taken request");

    // a new result appears only as the block returns to take the next sample
    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> i_in_ready)
        else $error("result appeared while input was blocked");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled output request changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("config channel not ready");

endmodule

bind biquad_direct_form2_filter_top biq_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_biq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_sample.valid),
    .i_out_ready (o_sample.ready),
    .i_out_data  (o_sample.sample_out),
    .i_cfg_ready (i_cfg.ready)
);

`default_nettype wire
